[rtl/ugl_pkg.sv]
// Shared types, constants and the column position table of the user glyph loader.
package ugl_pkg;

  localparam int NUM_SLOTS      = 95;
  localparam int COL_BYTES      = 36;
  localparam int FULL_COL_BYTES = 24;
  localparam int FULL_ROW_BASE  = 2;
  localparam int NIB_ROW_BASE   = 26;

  localparam logic [7:0] CODE_LO      = 8'h20;
  localparam logic [7:0] CODE_HI      = 8'h7E;
  localparam logic [7:0] Y_ARG        = 8'd3;
  localparam logic [7:0] X_ARG        = 8'd12;
  localparam logic [7:0] DEFINED_MARK = 8'h01;

  typedef enum logic [1:0] {
    FN_BEGIN  = 2'd0,
    FN_ARG    = 2'd1,
    FN_READ   = 2'd2,
    FN_CANCEL = 2'd3
  } func_t;

  // Store work that one item needs.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_SCATTER,
    ACT_READ
  } act_t;

  // Datapath operation for the current cycle.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_DECODE,
    OP_CLEAR,
    OP_SCATTER,
    OP_MARK,
    OP_READ
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
    logic commit;
  } ugl_cmd_t;

  typedef struct packed {
    logic seq_last;
    act_t act;
    logic mark;
  } ugl_stat_t;

  typedef struct packed {
    logic       full;
    logic [1:0] group;
    logic [2:0] col;
  } colpos_t;

  // Maps a column byte index to its row group and column. Bytes below 24 are
  // full-row columns 0..7, the rest are nibble columns 0..3 (col restarts from 0 there).
  function automatic colpos_t col_position(input logic [5:0] j);
    colpos_t    r;
    logic [1:0] g;
    logic [2:0] c;
    logic       full;
    r    = '0;
    g    = '0;
    c    = '0;
    full = 1'b1;
    for (int k = 0; k < COL_BYTES; k++) begin
      if (k == FULL_COL_BYTES) begin
        g    = '0;
        c    = '0;
        full = 1'b0;
      end
      if (j == 6'(k)) begin
        r.full  = full;
        r.group = g;
        r.col   = c;
      end
      if (g == 2'd2) begin
        g = '0;
        c = c + 3'd1;
      end else begin
        g = g + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

[rtl/user_glyph_loader.sv]
// Top level of the user glyph loader: controller plus datapath with the glyph store.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   func, data_byte, read_char, read_offset
//   output   out_valid / out_ready read_data, parse_active, rejected
//
// One item at a time. The scatter of a column byte steps through one store byte per cycle
// on the single read and single write port; the last nibble column byte also sets the
// defined byte. A valid x byte or a cancel of a code in range clears the slot.
// After reset the store is swept to zero with in_ready low.
// A result waiting on out_ready does not block the next accept, only its completion.
module user_glyph_loader #(
  parameter int SLOT_BYTES = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  input  logic [6:0] read_char,
  input  logic [5:0] read_offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       parse_active,
  output logic       rejected
);
  import ugl_pkg::*;

  ugl_cmd_t  cmd;
  ugl_stat_t stat;

  ugl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ugl_datapath #(
    .SLOT_BYTES (SLOT_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .data_byte    (data_byte),
    .read_char    (read_char),
    .read_offset  (read_offset),
    .read_data    (read_data),
    .parse_active (parse_active),
    .rejected     (rejected)
  );

endmodule

[rtl/ugl_ram.sv]
// Generic simple dual-port RAM with registered read data.
module ugl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ugl_datapath.sv]
// Datapath: item registers, command parser registers, glyph store and its sequencing.
module ugl_datapath #(
  parameter int SLOT_BYTES = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  ugl_pkg::ugl_cmd_t   cmd,
  output ugl_pkg::ugl_stat_t  stat,
  input  logic [1:0]          func,
  input  logic [7:0]          data_byte,
  input  logic [6:0]          read_char,
  input  logic [5:0]          read_offset,
  output logic [7:0]          read_data,
  output logic                parse_active,
  output logic                rejected
);
  import ugl_pkg::*;

  localparam int STORE_BYTES = NUM_SLOTS * SLOT_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int STEP_W      = $clog2(SLOT_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_Y,
    PH_C1,
    PH_C2,
    PH_DATA
  } phase_t;

  // Item registers.
  func_t       func_q;
  logic [7:0]  data_q;
  logic [6:0]  rc_q;
  logic [5:0]  ro_q;

  // Parser state.
  phase_t      phase, phase_next;
  logic [5:0]  cnt, cnt_next, cnt_inc;
  logic [6:0]  cur_char, cur_next, cur_inc;
  logic [6:0]  last_char, last_next;
  logic        rej;
  act_t        act;
  logic        mark;

  // Sequencing.
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] init_addr;
  logic [STEP_W-1:0] step;
  logic [6:0]        slot_sel;

  // Scatter.
  colpos_t           pos;
  logic [2:0]        idx;
  logic [7:0]        sh_full, sh_nib;
  logic [7:0]        scat_mask_now;
  logic [5:0]        scat_off;
  logic [3:0]        scat_steps;
  logic              scat_last;
  logic [ADDR_W-1:0] scat_waddr;
  logic [7:0]        scat_mask;

  // RAM port.
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, ram_rdata;

  // Results.
  logic [7:0]        read_data_q;
  logic              active_q, rej_q;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    cur_next   = cur_char;
    last_next  = last_char;
    rej        = 1'b0;
    act        = ACT_NONE;
    mark       = 1'b0;
    cnt_inc    = cnt + 6'd1;
    cur_inc    = cur_char + 7'd1;
    case (func_q)
      FN_BEGIN: begin
        phase_next = PH_Y;
        cnt_next   = '0;
      end
      FN_ARG: begin
        case (phase)
          PH_IDLE: begin
          end
          PH_Y: begin
            if (data_q != Y_ARG) begin
              rej = 1'b1;
            end else begin
              phase_next = PH_C1;
            end
          end
          PH_C1: begin
            if (data_q < CODE_LO || data_q > CODE_HI) begin
              rej = 1'b1;
            end else begin
              cur_next   = 7'(data_q - CODE_LO);
              phase_next = PH_C2;
            end
          end
          PH_C2: begin
            if (data_q < ({1'b0, cur_char} + CODE_LO) || data_q > CODE_HI) begin
              rej = 1'b1;
            end else begin
              last_next  = 7'(data_q - CODE_LO);
              cnt_next   = '0;
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (cnt == 6'd0) begin
              if (data_q != X_ARG) begin
                rej = 1'b1;
              end else begin
                act = ACT_CLEAR;
              end
            end else begin
              act = ACT_SCATTER;
            end
            if (!rej) begin
              // The last column byte completes the character.
              if (cnt_inc == 6'(COL_BYTES + 1)) begin
                mark     = 1'b1;
                cur_next = cur_inc;
                cnt_next = '0;
                if (cur_inc > last_char) begin
                  phase_next = PH_IDLE;
                end
              end else begin
                cnt_next = cnt_inc;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
        if (rej) begin
          phase_next = PH_IDLE;
          cnt_next   = '0;
        end
      end
      FN_READ: begin
        if (rc_q < 7'(NUM_SLOTS) && {1'b0, ro_q} < 7'(SLOT_BYTES)) begin
          act = ACT_READ;
        end
      end
      FN_CANCEL: begin
        if (data_q >= CODE_LO && data_q <= CODE_HI) begin
          act = ACT_CLEAR;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (func_q)
      FN_READ:   slot_sel = rc_q;
      FN_CANCEL: slot_sel = 7'(data_q - CODE_LO);
      default:   slot_sel = cur_char;
    endcase
  end

  // One store byte per scatter step: row offset and the bits to OR in.
  always_comb begin
    pos     = col_position(cnt - 6'd1);
    idx     = step[2:0];
    sh_full = data_q << idx;
    sh_nib  = data_q << {idx[1:0], 1'b0};
    if (pos.full) begin
      scat_steps    = 4'd8;
      scat_off      = 6'(FULL_ROW_BASE) + 6'({pos.group, 3'b000}) + 6'(idx);
      scat_mask_now = sh_full[7] ? (8'h80 >> pos.col) : 8'h00;
    end else begin
      scat_steps    = 4'd4;
      scat_off      = 6'(NIB_ROW_BASE) + 6'({pos.group, 2'b00}) + 6'(idx[1:0]);
      scat_mask_now = (sh_nib[7] ? (8'h80 >> pos.col) : 8'h00)
                    | (sh_nib[6] ? (8'h08 >> pos.col) : 8'h00);
    end
    scat_last = (step == STEP_W'(scat_steps));
  end

  always_comb begin
    stat.act  = act;
    stat.mark = mark;
    case (cmd.op)
      OP_INIT:    stat.seq_last = (init_addr == ADDR_W'(STORE_BYTES - 1));
      OP_CLEAR:   stat.seq_last = (step == STEP_W'(SLOT_BYTES - 1));
      OP_SCATTER: stat.seq_last = scat_last;
      default:    stat.seq_last = 1'b1;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base_addr;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = base_addr;
    case (cmd.op)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_addr;
      end
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = base_addr + ADDR_W'(step);
      end
      OP_SCATTER: begin
        // Read of step k overlaps the write back of step k-1.
        rd_en   = !scat_last;
        rd_addr = base_addr + ADDR_W'(scat_off);
        wr_en   = (step != '0);
        wr_addr = scat_waddr;
        wr_data = ram_rdata | scat_mask;
      end
      OP_MARK: begin
        wr_en   = 1'b1;
        wr_data = DEFINED_MARK;
      end
      OP_READ: begin
        rd_en   = 1'b1;
        rd_addr = base_addr + ADDR_W'(ro_q);
      end
      default: begin
      end
    endcase
  end

  ugl_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      cur_char  <= '0;
      last_char <= '0;
      init_addr <= '0;
      step      <= '0;
    end else begin
      if (cmd.op == OP_INIT) begin
        init_addr <= init_addr + ADDR_W'(1);
      end
      if (cmd.capture) begin
        step <= '0;
      end else if (cmd.op == OP_CLEAR || cmd.op == OP_SCATTER) begin
        step <= step + STEP_W'(1);
      end
      if (cmd.commit) begin
        phase     <= phase_next;
        cnt       <= cnt_next;
        cur_char  <= cur_next;
        last_char <= last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func_t'(func);
      data_q <= data_byte;
      rc_q   <= read_char;
      ro_q   <= read_offset;
    end
    if (cmd.op == OP_DECODE) begin
      base_addr <= ADDR_W'(slot_sel) * ADDR_W'(SLOT_BYTES);
    end
    if (cmd.op == OP_SCATTER && !scat_last) begin
      scat_waddr <= base_addr + ADDR_W'(scat_off);
      scat_mask  <= scat_mask_now;
    end
    if (cmd.commit) begin
      read_data_q <= (act == ACT_READ) ? ram_rdata : 8'h00;
      active_q    <= (phase_next != PH_IDLE);
      rej_q       <= rej;
    end
  end

  assign read_data    = read_data_q;
  assign parse_active = active_q;
  assign rejected     = rej_q;

endmodule

[rtl/ugl_ctrl.sv]
// Controller: handshakes and the sequence of datapath operations for each item.
module ugl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ugl_pkg::ugl_stat_t  stat,
  output ugl_pkg::ugl_cmd_t   cmd
);
  import ugl_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_SCATTER,
    S_MARK,
    S_READ,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   commit;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.commit  = commit;
    case (state)
      S_INIT:    cmd.op = OP_INIT;
      S_DECODE:  cmd.op = OP_DECODE;
      S_CLEAR:   cmd.op = OP_CLEAR;
      S_SCATTER: cmd.op = OP_SCATTER;
      S_MARK:    cmd.op = OP_MARK;
      S_READ:    cmd.op = OP_READ;
      default:   cmd.op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.seq_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.act)
          ACT_CLEAR:   state_next = S_CLEAR;
          ACT_SCATTER: state_next = S_SCATTER;
          ACT_READ:    state_next = S_READ;
          default:     state_next = S_FINISH;
        endcase
      end
      S_CLEAR: begin
        if (stat.seq_last) state_next = S_FINISH;
      end
      S_SCATTER: begin
        if (stat.seq_last) state_next = stat.mark ? S_MARK : S_FINISH;
      end
      S_MARK:   state_next = S_FINISH;
      S_READ:   state_next = S_FINISH;
      S_FINISH: begin
        if (commit) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/ugl_checker.sv]
// Port-level checks of the user glyph loader and their binding to the top level.
module ugl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       parse_active,
  input logic       rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data)
      && $stable(parse_active) && $stable(rejected))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("handshake active right after reset");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reject_ends_parse: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> !parse_active)
    else $error("rejected item left the parser active");

  a_reject_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> read_data == 8'd0)
    else $error("rejected item carries read data");

endmodule

bind user_glyph_loader ugl_checker u_checker (.*);

[bench/user_glyph_loader_tb.sv]
// Self-checking testbench for user_glyph_loader: define commands, reads and cancels.
module user_glyph_loader_tb;
  import ugl_pkg::*;

  localparam int SLOT_BYTES = 40;
  localparam int STORE_BYTES = NUM_SLOTS * SLOT_BYTES;
  localparam int GLYPH_ARGS = COL_BYTES + 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_Y,
    PH_C1,
    PH_C2,
    PH_DATA
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       parse_active;
    logic       rejected;
  } glyph_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FN_BEGIN;
  logic [7:0] data_byte = '0;
  logic [6:0] read_char = '0;
  logic [5:0] read_offset = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       parse_active;
  logic       rejected;

  // Shadow of the parser and the glyph store.
  parse_phase_t g_phase = PH_IDLE;
  logic [5:0]   g_count = '0;
  logic [6:0]   g_cur = '0;
  logic [6:0]   g_last = '0;
  logic [7:0]   shadow_glyphs [STORE_BYTES];

  glyph_result_t pending_results [$];
  bit quiet = 1'b0;
  int n_errors = 0;
  int n_effective = 0;
  int n_glyphs = 0;
  int n_rejects = 0;
  int n_reads = 0;

  user_glyph_loader #(.SLOT_BYTES(SLOT_BYTES)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .data_byte(data_byte),
    .read_char(read_char),
    .read_offset(read_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .parse_active(parse_active),
    .rejected(rejected)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = quiet || ($urandom_range(99) >= 11);
  end

  function automatic void wipe_slot(input int slot);
    if (slot < NUM_SLOTS)
      for (int i = 0; i < SLOT_BYTES; i++) shadow_glyphs[slot * SLOT_BYTES + i] = 8'h00;
  endfunction

  // Column byte j feeds eight rows of one column; nibble columns pack two rows a byte.
  function automatic void paint_column(input int slot, input int j, input logic [7:0] d);
    int         jj;
    int         grp;
    int         col;
    int         row;
    int         idx;
    logic [7:0] mask;
    if (slot >= NUM_SLOTS) return;
    jj  = (j < FULL_COL_BYTES) ? j : j - FULL_COL_BYTES;
    grp = jj % 3;
    col = jj / 3;
    for (int i = 0; i < 8; i++) begin
      if (d[7-i]) begin
        row = grp * 8 + i;
        if (j < FULL_COL_BYTES) begin
          idx  = FULL_ROW_BASE + row;
          mask = 8'h80 >> col;
        end else begin
          idx  = NIB_ROW_BASE + row / 2;
          mask = (row % 2 == 0) ? (8'h80 >> col) : (8'h08 >> col);
        end
        if (idx < SLOT_BYTES) shadow_glyphs[slot * SLOT_BYTES + idx] |= mask;
      end
    end
  endfunction

  // Returns 1 when the argument byte aborts the command.
  function automatic logic take_arg(input logic [7:0] d);
    case (g_phase)
      PH_Y: begin
        if (d != Y_ARG) return 1'b1;
        g_phase = PH_C1;
      end
      PH_C1: begin
        if (d < CODE_LO || d > CODE_HI) return 1'b1;
        g_cur   = 7'(d - CODE_LO);
        g_phase = PH_C2;
      end
      PH_C2: begin
        if (int'(d) < int'(g_cur) + int'(CODE_LO) || d > CODE_HI) return 1'b1;
        g_last  = 7'(d - CODE_LO);
        g_count = '0;
        g_phase = PH_DATA;
      end
      PH_DATA: begin
        if (g_count == 0) begin
          if (d != X_ARG) return 1'b1;
          wipe_slot(int'(g_cur));
        end else begin
          paint_column(int'(g_cur), int'(g_count) - 1, d);
        end
        g_count = g_count + 6'd1;
        if (int'(g_count) == GLYPH_ARGS) begin
          if (g_cur < NUM_SLOTS) shadow_glyphs[int'(g_cur) * SLOT_BYTES] = DEFINED_MARK;
          g_cur   = g_cur + 7'd1;
          g_count = '0;
          n_glyphs++;
          if (g_cur > g_last) g_phase = PH_IDLE;
        end
      end
      default: g_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic glyph_result_t predict_glyph_step(input logic [1:0] f,
                                                      input logic [7:0] d,
                                                      input logic [6:0] rc,
                                                      input logic [5:0] ro);
    glyph_result_t r;
    r = '0;
    case (func_t'(f))
      FN_BEGIN: begin
        g_phase = PH_Y;
        g_count = '0;
      end
      FN_ARG: begin
        if (g_phase != PH_IDLE) begin
          r.rejected = take_arg(d);
          if (r.rejected) begin
            g_phase = PH_IDLE;
            g_count = '0;
            n_rejects++;
          end
        end
      end
      FN_READ: begin
        n_reads++;
        if (rc < NUM_SLOTS && ro < SLOT_BYTES)
          r.read_data = shadow_glyphs[int'(rc) * SLOT_BYTES + int'(ro)];
      end
      default: begin
        if (d >= CODE_LO && d <= CODE_HI) wipe_slot(int'(d - CODE_LO));
      end
    endcase
    r.parse_active = (g_phase != PH_IDLE);
    return r;
  endfunction

  // Prediction on accept and comparison on delivery share one process, so their
  // order is fixed: the prediction runs before the comparison.
  always @(posedge clk) begin : scoreboard
    glyph_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (!((func == FN_ARG && g_phase == PH_IDLE) ||
              (func == FN_CANCEL && (data_byte < CODE_LO || data_byte > CODE_HI))))
          n_effective++;
        pending_results.push_back(predict_glyph_step(func, data_byte, read_char, read_offset));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item pending");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, read_data);
            n_errors++;
          end
          if (parse_active !== want.parse_active) begin
            $error("parse_active: expected %0b, got %0b", want.parse_active, parse_active);
            n_errors++;
          end
          if (rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, rejected);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic send_item(input func_t f, input logic [7:0] d, input logic [6:0] rc,
                           input logic [5:0] ro);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    func        = f;
    data_byte   = d;
    read_char   = rc;
    read_offset = ro;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_begin();
    send_item(FN_BEGIN, 8'($urandom), 7'($urandom), 6'($urandom));
  endtask

  task automatic send_arg(input logic [7:0] d);
    send_item(FN_ARG, d, 7'($urandom), 6'($urandom));
  endtask

  task automatic send_read(input logic [6:0] rc, input logic [5:0] ro);
    send_item(FN_READ, 8'($urandom), rc, ro);
  endtask

  task automatic send_cancel(input logic [7:0] code);
    send_item(FN_CANCEL, code, 7'($urandom), 6'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] column_value();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends a define command for codes c1..c2. At argument position break_at a bad byte
  // (or, inside column data, a new begin) cuts the command short; -1 runs it through.
  task automatic define_glyphs(input logic [7:0] c1, input logic [7:0] c2,
                               input int break_at, input int noise_pct);
    int         pos;
    logic [7:0] b;
    send_begin();
    if (break_at == 0) begin
      b = 8'($urandom);
      send_arg(b == Y_ARG ? b + 8'd1 : b);
      return;
    end
    send_arg(Y_ARG);
    if (break_at == 1) begin
      send_arg($urandom_range(1) ? 8'($urandom_range(CODE_LO - 1))
                                 : 8'($urandom_range(255, CODE_HI + 1)));
      return;
    end
    send_arg(c1);
    if (break_at == 2) begin
      send_arg((c1 > CODE_LO && $urandom_range(1)) ? 8'($urandom_range(c1 - 1))
                                                   : 8'($urandom_range(255, CODE_HI + 1)));
      return;
    end
    send_arg(c2);
    pos = 3;
    for (int c = c1; c <= c2; c++) begin
      for (int k = 0; k < GLYPH_ARGS; k++) begin
        if (pos == break_at) begin
          if (k == 0) begin
            b = 8'($urandom);
            send_arg(b == X_ARG ? b + 8'd1 : b);
          end else begin
            send_begin();
          end
          return;
        end
        if ($urandom_range(99) < noise_pct) begin
          if ($urandom_range(1))
            send_read(7'($urandom_range(c2 - CODE_LO, c1 - CODE_LO)),
                      6'($urandom_range(SLOT_BYTES - 1)));
          else
            send_cancel($urandom_range(3) == 0 ? 8'(c) : 8'($urandom));
        end
        send_arg(k == 0 ? X_ARG : column_value());
        pos++;
      end
    end
  endtask

  task automatic read_whole_slot(input int slot);
    for (int i = 0; i < SLOT_BYTES; i++) send_read(7'(slot), 6'(i));
  endtask

  task automatic test_reset_reads();
    send_read(7'd0, 6'd0);
    send_read(7'd94, 6'(SLOT_BYTES - 1));
    send_read(7'd127, 6'd63);
    send_read(7'd95, 6'(SLOT_BYTES));
  endtask

  task automatic test_idle_noise();
    send_arg(8'hFF);
    send_arg(8'h00);
    send_cancel(8'h1F);
    send_cancel(8'h7F);
  endtask

  task automatic test_header_errors();
    define_glyphs(CODE_LO, CODE_LO, 0, 0);
    define_glyphs(CODE_LO, CODE_LO, 1, 0);
    // A second begin restarts the parser at y.
    send_begin();
    define_glyphs(8'h50, 8'h50, 2, 0);
    send_begin();
    send_arg(Y_ARG);
    send_arg(8'h50);
    send_arg(8'h4F);
    define_glyphs(CODE_HI, CODE_HI, 3, 0);
  endtask

  task automatic test_edge_glyphs();
    define_glyphs(CODE_LO, CODE_LO, -1, 0);
    read_whole_slot(0);
    define_glyphs(CODE_HI - 8'd1, CODE_HI, -1, 0);
    read_whole_slot(NUM_SLOTS - 1);
    send_read(7'd94, 6'd63);
  endtask

  task automatic test_cancel_in_define();
    define_glyphs(8'h41, 8'h42, -1, 30);
    read_whole_slot(8'h41 - CODE_LO);
    send_cancel(8'h41);
    read_whole_slot(8'h41 - CODE_LO);
  endtask

  task automatic test_restart_in_data();
    define_glyphs(8'h30, 8'h31, 3 + GLYPH_ARGS + 10, 0);
    send_arg(Y_ARG);
    send_arg(8'h31);
    send_arg(8'h31);
    send_arg(X_ARG);
    send_arg(8'hA5);
    read_whole_slot(8'h31 - CODE_LO);
  endtask

  task automatic test_random_traffic(input int target);
    int         pick;
    int         span;
    logic [7:0] c1;
    logic [7:0] c2;
    while (n_effective < target) begin
      pick = $urandom_range(99);
      c1   = 8'($urandom_range(CODE_HI, CODE_LO));
      span = (CODE_HI - c1 < 2) ? int'(CODE_HI - c1) : 2;
      c2   = c1 + 8'($urandom_range(span));
      if (pick < 55) begin
        define_glyphs(c1, c2, -1, 5);
        repeat ($urandom_range(10, 3))
          send_read(7'($urandom_range(c2 - CODE_LO, c1 - CODE_LO)),
                    6'($urandom_range(SLOT_BYTES - 1)));
      end else if (pick < 70) begin
        define_glyphs(c1, c2, $urandom_range(3 + GLYPH_ARGS * (c2 - c1 + 1) - 1), 5);
      end else if (pick < 82) begin
        repeat (4) send_read(7'($urandom), 6'($urandom));
      end else if (pick < 90) begin
        send_cancel($urandom_range(1) ? c1 : 8'($urandom));
      end else if (pick < 95) begin
        repeat ($urandom_range(3, 1)) send_arg(8'($urandom));
      end else begin
        send_begin();
        repeat ($urandom_range(3, 1)) send_arg(8'($urandom));
      end
    end
  endtask

  initial begin
    foreach (shadow_glyphs[i]) shadow_glyphs[i] = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_reads();
    test_idle_noise();
    test_header_errors();
    drain_results();
    test_edge_glyphs();
    test_cancel_in_define();
    test_restart_in_data();
    drain_results();
    quiet = 1'b1;
    test_random_traffic(n_effective + 200);
    drain_results();
    quiet = 1'b0;
    test_random_traffic(n_effective + 550);

    drain_results();
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_errors++;
    end
    $display("Covered %0d effective items: %0d glyphs fully defined, %0d arguments rejected,",
             n_effective, n_glyphs, n_rejects);
    $display("and %0d store reads, with and without random stalls on both channels.", n_reads);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/ugl_pkg.sv
rtl/ugl_ram.sv
rtl/ugl_datapath.sv
rtl/ugl_ctrl.sv
rtl/user_glyph_loader.sv
rtl/ugl_checker.sv
bench/user_glyph_loader_tb.sv
